FILE: design/talc_pkg.sv
// ----------------------------------------------------------------------------
// talc_pkg
// Shared types and constants of the tinted alpha layer compositor: item
// structs, command and register codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package talc_pkg;

    // default canvas store size
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // command codes
    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_BLEND = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA = 3'd4;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [8:0]  RST_WIDTH     = 9'd256;
    localparam logic [8:0]  RST_HEIGHT    = 9'd256;
    localparam logic [31:0] RST_BASE      = 32'h0000_0000;
    localparam logic [31:0] RST_TINT      = 32'hFFFF_FFFF;
    localparam logic        RST_HAS_ALPHA = 1'b1;

    // channel math: floor(num / 65025) as (num * DIV_MUL) >> DIV_SHIFT,
    // exact for num below 2^24
    localparam logic [7:0]  ALPHA_MAX  = 8'd255;
    localparam int          NUM_W      = 24;
    localparam int          DIV_MUL_W  = 25;
    localparam int          PROD_W     = NUM_W + DIV_MUL_W;
    localparam int          DIV_SHIFT  = 40;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 25'd16909061;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] dest_x;
        logic [7:0] dest_y;
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
        logic       clipped;
    } t_out_item;

    // what goes into the result register
    typedef enum logic [2:0] {
        OUT_FILL  = 3'd0,
        OUT_NONE  = 3'd1,
        OUT_CLIP  = 3'd2,
        OUT_READ  = 3'd3,
        OUT_BLEND = 3'd4
    } t_out_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     load_item;
        logic     fill_step;
        logic     lookup;
        logic     mul1;
        logic     mul2;
        logic     scale;
        logic     write_back;
        logic     load_out;
        t_out_sel out_sel;
    } t_ctrl;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       clip;
        logic       fill_last;
    } t_stat;

endpackage

FILE: design/talc_datapath.sv
// ----------------------------------------------------------------------------
// talc_datapath
// Configuration registers, canvas store, address and clip logic, the
// four-lane blend pipeline and the result register.
// ----------------------------------------------------------------------------
module talc_datapath #(
    parameter int MAX_WIDTH  = talc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = talc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [talc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [talc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  talc_pkg::t_in_item               i_item,
    input  talc_pkg::t_ctrl                  i_ctrl,
    output talc_pkg::t_stat                  o_stat,
    output talc_pkg::t_out_item              o_result
);
    import talc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIN_W = 17;

    // configuration registers
    logic [8:0]  r_cfg_w;
    logic [8:0]  r_cfg_h;
    logic [31:0] r_base;
    logic [31:0] r_tint;
    logic        r_has_alpha;

    // item and pipeline registers
    t_in_item    r_item;
    logic [AW-1:0] r_fill_cnt;
    logic [AW-1:0] r_addr;
    logic [31:0] r_rdata;
    logic [31:0] r_old;
    logic [7:0]  r_a;
    logic [15:0] r_p1 [4];
    logic [15:0] r_q1 [4];
    logic [NUM_W-1:0] r_num [4];
    logic [31:0] r_new;
    t_out_item   r_out;
    logic [31:0] r_canvas [DEPTH];

    logic [8:0]  w_eff;
    logic [8:0]  h_eff;
    logic        clip;
    logic [LIN_W-1:0] lin;
    logic [AW-1:0] look_addr;
    logic [7:0]  src [4];
    logic [7:0]  a_eff;
    logic [31:0] n_new;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= RST_WIDTH;
            r_cfg_h     <= RST_HEIGHT;
            r_base      <= RST_BASE;
            r_tint      <= RST_TINT;
            r_has_alpha <= RST_HAS_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:     r_cfg_w     <= i_cfg_data[8:0];
                CFG_HEIGHT:    r_cfg_h     <= i_cfg_data[8:0];
                CFG_BASE:      r_base      <= i_cfg_data;
                CFG_TINT:      r_tint      <= i_cfg_data;
                CFG_HAS_ALPHA: r_has_alpha <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective canvas size, saturated at the store size
    always_comb begin
        w_eff = ({23'd0, r_cfg_w} > 32'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : r_cfg_w;
        h_eff = ({23'd0, r_cfg_h} > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : r_cfg_h;
        clip  = ({1'b0, r_item.dest_x} >= w_eff) || ({1'b0, r_item.dest_y} >= h_eff);
        lin   = LIN_W'({9'd0, r_item.dest_y} * {8'd0, w_eff}) + {9'd0, r_item.dest_x};
        look_addr = AW'(lin);
    end

    // item capture and fill sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt <= '0;
        end else if (i_ctrl.load_item) begin
            r_fill_cnt <= '0;
        end else if (i_ctrl.fill_step) begin
            r_fill_cnt <= r_fill_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) begin
            r_item <= i_item;
        end
        if (i_ctrl.lookup) begin
            r_addr <= look_addr;
        end
    end

    // canvas store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill_step) begin
            r_canvas[r_fill_cnt] <= r_base;
        end else if (i_ctrl.write_back) begin
            r_canvas[r_addr] <= r_new;
        end
        if (i_ctrl.lookup) begin
            r_rdata <= r_canvas[look_addr];
        end
    end

    // source lanes, red first
    always_comb begin
        src[0] = r_item.src_red;
        src[1] = r_item.src_green;
        src[2] = r_item.src_blue;
        src[3] = r_item.src_alpha;
        a_eff  = r_has_alpha ? r_item.src_alpha : r_tint[7:0];
    end

    // blend pipeline: products, weighted sum, scale by 1/65025
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul1) begin
            r_old <= r_rdata;
            r_a   <= a_eff;
            for (int k = 0; k < 4; k++) begin
                r_p1[k] <= 16'(src[k]) * 16'(r_tint[31-8*k -: 8]);
                r_q1[k] <= 16'(r_rdata[31-8*k -: 8]) * 16'(ALPHA_MAX - a_eff);
            end
        end
        if (i_ctrl.mul2) begin
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= NUM_W'(25'(r_p1[k]) * 25'(r_a)
                                   + 25'({r_q1[k], 8'd0}) - 25'(r_q1[k]));
            end
        end
        if (i_ctrl.scale) begin
            r_new <= n_new;
        end
    end

    always_comb begin
        logic [PROD_W-1:0] prod;
        logic [8:0]        q;
        n_new = r_old;
        for (int k = 0; k < 4; k++) begin
            prod = PROD_W'(r_num[k]) * PROD_W'(DIV_MUL);
            q    = prod[PROD_W-1:DIV_SHIFT];
            // alpha lane keeps the canvas byte for rgb sources
            if (k < 3 || r_has_alpha) begin
                n_new[31-8*k -: 8] = (q > 9'd255) ? 8'd255 : q[7:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            case (i_ctrl.out_sel)
                OUT_FILL:  r_out <= {r_base, 1'b0};
                OUT_CLIP:  r_out <= {32'd0, 1'b1};
                OUT_READ:  r_out <= {r_rdata, 1'b0};
                OUT_BLEND: r_out <= {r_new, 1'b0};
                default:   r_out <= {32'd0, 1'b0};
            endcase
        end
    end

    assign o_stat.cmd       = r_item.command;
    assign o_stat.clip      = clip;
    assign o_stat.fill_last = (r_fill_cnt == AW'(DEPTH - 1));
    assign o_result         = r_out;

endmodule

FILE: design/talc_ctrl.sv
// ----------------------------------------------------------------------------
// talc_ctrl
// Command sequencer: fill sweep, lookup, read response and the blend
// read-modify-write steps, plus the result strobe.
// ----------------------------------------------------------------------------
module talc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_command,
    input  talc_pkg::t_stat  i_stat,
    output talc_pkg::t_ctrl  o_ctrl,
    output logic             o_busy,
    output logic             o_done
);
    import talc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FILL   = 7'b0000010,
        S_LOOKUP = 7'b0000100,
        S_FETCH  = 7'b0001000,
        S_MUL2   = 7'b0010000,
        S_SCALE  = 7'b0100000,
        S_WRITE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_ctrl  = '0;
        o_ctrl.out_sel = OUT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_ctrl.load_item = 1'b1;
                    n_state = (i_command == CMD_FILL) ? S_FILL : S_LOOKUP;
                end
            end
            S_FILL: begin
                o_ctrl.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    o_ctrl.load_out = 1'b1;
                    o_ctrl.out_sel  = OUT_FILL;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LOOKUP: begin
                o_ctrl.lookup = 1'b1;
                if (i_stat.cmd == CMD_NONE) begin
                    o_ctrl.load_out = 1'b1;
                    o_ctrl.out_sel  = OUT_NONE;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.clip) begin
                    o_ctrl.load_out = 1'b1;
                    o_ctrl.out_sel  = OUT_CLIP;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_stat.cmd == CMD_READ) begin
                    o_ctrl.load_out = 1'b1;
                    o_ctrl.out_sel  = OUT_READ;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_ctrl.mul1 = 1'b1;
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                o_ctrl.mul2 = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_ctrl.scale = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_ctrl.write_back = 1'b1;
                o_ctrl.load_out   = 1'b1;
                o_ctrl.out_sel    = OUT_BLEND;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    // an accepted item always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

    // the strobe shows only after a finishing state, back in idle
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE) && ($past(r_state) == S_FILL
            || $past(r_state) == S_LOOKUP || $past(r_state) == S_FETCH
            || $past(r_state) == S_WRITE))
        else $error("result strobe without a finished item");

    // the fill sweep runs to its last word
    a_fill_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && !i_stat.fill_last) |=> (r_state == S_FILL))
        else $error("fill sweep cut short");

    // a blend writes back exactly once, after the fetch and the mul2 and scale steps
    a_blend_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.mul1 |-> ##3 o_ctrl.write_back)
        else $error("blend did not write back");

endmodule

FILE: design/tinted_alpha_layer_compositor_core.sv
// ----------------------------------------------------------------------------
// tinted_alpha_layer_compositor_core
// an accepted item goes to lookup, or to the fill sweep that writes one store
// word per cycle; clipped or unused items finish in lookup, reads in fetch,
// blends in write. A new item is taken in the cycle its predecessor's strobe
// shows; the blend is a read, three arithmetic steps and a write on the canvas
// store, which has one write port and one registered read port
// synchronous active-low reset restores the config registers, fill counter,
// state and strobe; canvas undefined until filled; results cannot be stalled
// ----------------------------------------------------------------------------
module tinted_alpha_layer_compositor_core #(
    parameter int MAX_WIDTH  = talc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = talc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [talc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [talc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  talc_pkg::t_in_item               i_item,
    output logic                             o_done,
    output talc_pkg::t_out_item              o_result
);
    import talc_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // sequencer
    talc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_stat    (stat),
        .o_ctrl    (ctrl),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    // canvas and arithmetic
    talc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule
